FILE: src/gre_pkg.sv
// gre_pkg: shared types and constants of the graph reachability engine
// no dependencies
`default_nettype none
package gre_pkg;
  localparam int unsigned Nodes = 16;
  localparam int unsigned NodeW = 4;
  localparam int unsigned CntW = 5;
  localparam int unsigned AdjAddrW = 8;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0, ACT_DEL = 3'd1, ACT_REACH = 3'd2, ACT_PATH = 3'd3, ACT_CONN = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_RANGE = 2'd1, ST_DUP = 2'd2, ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_REQ, S_SCAN_CHK, S_DEL_RD, S_DEL_WR,
    S_WALK_TOP, S_WALK_RD, S_WALK_CHK, S_CONN_NEXT, S_CONN_CHK,
    S_PATH_RD, S_PATH_OUT, S_OUT
  } state_e;
endpackage
`default_nettype wire

FILE: src/graph_reachability_engine.sv
// graph reachability engine: adjacency lists in ram, depth-first walk sequencer
// an add or delete scans the source node's entries, a walk reads the adjacency entries of
// each visited node, and the connectivity check runs up to one walk per node
// throughput: one item at a time, the next is taken once its last result word has left
// reset: lengths, marks and node_count clear at once, no clearing pass; depends on gre_pkg, gre_ram
`default_nettype none
module graph_reachability_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,   // node_count [4:0]
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i, // action[2:0] from_node[6:3] to_node[10:7]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o, // status[1:0] answer[2] path_node[6:3]
  output logic             m_axis_tlast_o
);
  import gre_pkg::*;

  state_e st_q, st_d;
  logic [CntW-1:0] ncnt_q;
  logic [2:0] act_q;
  logic [NodeW-1:0] from_q, to_q;
  logic [CntW-1:0] len_q [Nodes];
  logic [Nodes-1:0] vis_q;
  logic [CntW-1:0] i_q, i_d;         // scan index / connectivity column
  logic [CntW-1:0] sp_q, sp_d;       // stack depth
  logic [CntW-1:0] root_q, root_d;   // connectivity start node
  logic [NodeW-1:0] v_q, v_d;
  logic [CntW-1:0] p_q, p_d;
  logic [CntW-1:0] k_q, k_d;
  logic [1:0] ost_q, ost_d;
  logic ans_q, ans_d;
  logic [NodeW-1:0] onode_q, onode_d;
  logic olast_q, olast_d;
  logic ovld_q, ovld_d;

  // adjacency ram
  logic adj_we;
  logic [AdjAddrW-1:0] adj_wa, adj_ra;
  logic [NodeW-1:0] adj_wd, adj_rd;
  gre_ram #(.Width(NodeW), .Depth(Nodes*Nodes)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd));

  // stack ram: node and position packed
  logic stk_we;
  logic [NodeW-1:0] stk_wa, stk_ra;
  logic [NodeW+CntW-1:0] stk_wd, stk_rd;
  gre_ram #(.Width(NodeW+CntW), .Depth(Nodes)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  logic [CntW-1:0] nact;
  assign nact = (ncnt_q > CntW'(Nodes)) ? CntW'(Nodes) : ncnt_q;

  logic [CntW-1:0] flen;
  assign flen = (len_q[from_q] > CntW'(Nodes)) ? CntW'(Nodes) : len_q[from_q];
  logic [CntW-1:0] vlen;
  assign vlen = len_q[v_q];

  logic in_ok;
  assign in_ok = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (st_q == S_IDLE) && !ovld_q;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o = {1'b0, onode_q, ans_q, ost_q};
  assign m_axis_tlast_o = olast_q;

  logic vis_clr, vis_set;
  logic [NodeW-1:0] vis_idx;
  logic len_we;
  logic [CntW-1:0] len_wd;

  always_comb begin
    st_d = st_q; i_d = i_q; sp_d = sp_q; root_d = root_q; v_d = v_q; p_d = p_q;
    k_d = k_q; ost_d = ost_q; ans_d = ans_q; onode_d = onode_q; olast_d = olast_q;
    ovld_d = ovld_q;
    adj_we = 1'b0; adj_wa = {from_q, i_q[NodeW-1:0]}; adj_wd = to_q;
    adj_ra = {from_q, i_q[NodeW-1:0]};
    stk_we = 1'b0; stk_wa = sp_q[NodeW-1:0]; stk_wd = {v_q, p_q};
    stk_ra = NodeW'(sp_q - 1'b1);
    vis_clr = 1'b0; vis_set = 1'b0; vis_idx = v_q;
    len_we = 1'b0; len_wd = flen;
    if (ovld_q && m_axis_tready_i) ovld_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_ok) begin
          i_d = '0; ost_d = ST_OK; ans_d = 1'b0; onode_d = '0; olast_d = 1'b1;
          if (s_axis_tdata_i[2:0] > ACT_CONN) begin
            st_d = S_OUT;
          end else if (s_axis_tdata_i[2:0] == ACT_CONN) begin
            root_d = '0; st_d = S_CONN_NEXT;
          end else if ({1'b0, s_axis_tdata_i[6:3]} >= nact ||
                       {1'b0, s_axis_tdata_i[10:7]} >= nact) begin
            ost_d = ST_RANGE; st_d = S_OUT;
          end else if (s_axis_tdata_i[2:0] == ACT_ADD ||
                       s_axis_tdata_i[2:0] == ACT_DEL) begin
            st_d = S_SCAN_REQ;
          end else if (s_axis_tdata_i[6:3] == s_axis_tdata_i[10:7]) begin
            // only a path query reports the node itself
            ans_d = 1'b1; st_d = S_OUT;
            if (s_axis_tdata_i[2:0] == ACT_PATH) onode_d = s_axis_tdata_i[10:7];
          end else begin
            vis_clr = 1'b1;
            v_d = s_axis_tdata_i[6:3]; p_d = '0; sp_d = '0; st_d = S_WALK_TOP;
          end
        end
      end
      S_SCAN_REQ: begin
        if (i_q >= flen) begin
          if (act_q == ACT_DEL) ost_d = ST_ABSENT;
          else if (flen >= CntW'(Nodes)) ost_d = ST_DUP;
          else begin
            adj_we = 1'b1; len_we = 1'b1; len_wd = flen + 1'b1; ans_d = 1'b1;
          end
          st_d = S_OUT;
        end else st_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (adj_rd == to_q) begin
          if (act_q == ACT_ADD) begin
            ost_d = ST_DUP; st_d = S_OUT;
          end else begin
            st_d = S_DEL_RD;
          end
        end else begin
          i_d = i_q + 1'b1; st_d = S_SCAN_REQ;
        end
      end
      S_DEL_RD: begin
        adj_ra = {from_q, NodeW'(flen - 1'b1)};
        st_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        adj_we = 1'b1; adj_wd = adj_rd; len_we = 1'b1; len_wd = flen - 1'b1;
        ans_d = 1'b1; st_d = S_OUT;
      end
      // push current (v,p) frame: v_q/p_q hold top of stack in registers
      S_WALK_TOP: begin
        // on entry v_q is a new node to push
        vis_set = 1'b1; vis_idx = v_q; p_d = '0; sp_d = sp_q + 1'b1;
        st_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (p_q >= vlen || p_q >= CntW'(Nodes)) begin
          if (sp_q == CntW'(1)) begin
            sp_d = '0;
            st_d = (act_q == ACT_CONN) ? S_CONN_CHK : S_OUT;
            i_d = '0;
          end else begin
            sp_d = sp_q - 1'b1;
            stk_ra = NodeW'(sp_q - 2'd2);
            st_d = S_PATH_RD; // pop: reload frame
          end
        end else begin
          adj_ra = {v_q, p_q[NodeW-1:0]};
          st_d = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        p_d = p_q + 1'b1;
        if (act_q != ACT_CONN && adj_rd == to_q) begin
          ans_d = 1'b1; onode_d = to_q; k_d = CntW'(1);
          olast_d = (sp_q == '0);
          stk_we = 1'b1; stk_wa = NodeW'(sp_q - 1'b1); stk_wd = {v_q, p_q + 1'b1};
          if (act_q == ACT_REACH) begin
            olast_d = 1'b1; onode_d = '0; st_d = S_OUT;
          end else begin
            olast_d = 1'b0; ovld_d = 1'b1; st_d = S_PATH_OUT;
          end
        end else if (!vis_q[adj_rd] && sp_q < CntW'(Nodes)) begin
          stk_we = 1'b1; stk_wa = NodeW'(sp_q - 1'b1); stk_wd = {v_q, p_q + 1'b1};
          v_d = adj_rd; st_d = S_WALK_TOP;
        end else st_d = S_WALK_RD;
      end
      S_PATH_RD: begin
        // frame data arrives from stack ram
        if (act_q == ACT_PATH && ans_q) begin
          onode_d = stk_rd[NodeW+CntW-1:CntW];
          olast_d = (sp_q == '0) || (k_q == CntW'(Nodes-1));
          ovld_d = 1'b1; k_d = k_q + 1'b1;
          st_d = olast_d ? S_IDLE : S_PATH_OUT;
        end else begin
          v_d = stk_rd[NodeW+CntW-1:CntW]; p_d = stk_rd[CntW-1:0];
          st_d = S_WALK_RD;
        end
      end
      S_PATH_OUT: begin
        if (!ovld_q || m_axis_tready_i) begin
          sp_d = sp_q - 1'b1;
          stk_ra = NodeW'(sp_q - 1'b1);
          st_d = S_PATH_RD;
        end
      end
      S_CONN_NEXT: begin
        if (root_q >= nact) begin
          ans_d = 1'b1; st_d = S_OUT;
        end else begin
          vis_clr = 1'b1; v_d = root_q[NodeW-1:0]; sp_d = '0; st_d = S_WALK_TOP;
        end
      end
      S_CONN_CHK: begin
        if (i_q >= nact) begin
          root_d = root_q + 1'b1; st_d = S_CONN_NEXT;
        end else if (!vis_q[i_q[NodeW-1:0]]) begin
          st_d = S_OUT;
        end else i_d = i_q + 1'b1;
      end
      S_OUT: begin
        ovld_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ncnt_q <= '0; vis_q <= '0; ovld_q <= 1'b0;
      for (int n = 0; n < Nodes; n++) len_q[n] <= '0;
    end else begin
      st_q <= st_d; ovld_q <= ovld_d;
      if (cfg_valid_i) ncnt_q <= cfg_data_i[CntW-1:0];
      if (vis_clr) vis_q <= '0;
      else if (vis_set) vis_q[vis_idx] <= 1'b1;
      if (len_we) len_q[from_q] <= len_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ok) begin
      act_q <= s_axis_tdata_i[2:0]; from_q <= s_axis_tdata_i[6:3];
      to_q <= s_axis_tdata_i[10:7];
    end
    i_q <= i_d; sp_q <= sp_d; root_q <= root_d; v_q <= v_d; p_q <= p_d; k_q <= k_d;
    ost_q <= ost_d; ans_q <= ans_d; onode_q <= onode_d; olast_q <= olast_d;
  end
endmodule
`default_nettype wire

FILE: src/gre_ram.sv
// gre_ram: generic single-port-write, one-read synchronous ram
// registered read data, no dependencies
`default_nettype none
module gre_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
